// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and operation codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_INC = 3'd4,
        ACT_DEC = 3'd5
    } action_t;

endpackage

// ===== rtl/core/cau_if.sv =====
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels for operation requests and complex results.
// ----------------------------------------------------------------------------
interface cau_req_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic signed [W-1:0] a_real;
    logic signed [W-1:0] a_imag;
    logic signed [W-1:0] b_real;
    logic signed [W-1:0] b_imag;

    modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_real;
    logic signed [W-1:0] res_imag;
    logic                overflow;
    logic                div_by_zero;

    modport source (output valid, res_real, res_imag, overflow, div_by_zero, input ready);
    modport sink   (input valid, res_real, res_imag, overflow, div_by_zero, output ready);
endinterface

// ===== rtl/core/cau_div_stage.sv =====
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring-division step for both quotient parts against a shared
// denominator, registered, with side information carried alongside.
// ----------------------------------------------------------------------------
module cau_div_stage
    import cau_pkg::*;
#(
    parameter int RW     = 65,
    parameter int QW     = 33,
    parameter int DW     = 64,
    parameter int SIDE_W = 8
)(
    input  logic              clk,
    input  logic              en,
    input  logic [RW-1:0]     r_re,
    input  logic [RW-1:0]     r_im,
    input  logic [QW-1:0]     q_re,
    input  logic [QW-1:0]     q_im,
    input  logic [QW-1:0]     low_re,
    input  logic [QW-1:0]     low_im,
    input  logic [DW-1:0]     den,
    input  logic [SIDE_W-1:0] side,
    output logic [RW-1:0]     r_re_o,
    output logic [RW-1:0]     r_im_o,
    output logic [QW-1:0]     q_re_o,
    output logic [QW-1:0]     q_im_o,
    output logic [QW-1:0]     low_re_o,
    output logic [QW-1:0]     low_im_o,
    output logic [DW-1:0]     den_o,
    output logic [SIDE_W-1:0] side_o
);

    logic [RW-1:0] sh_re, sh_im, dx;
    logic          ge_re, ge_im;
    logic [RW-1:0] r_re_next, r_im_next;

    always_comb
    begin
        dx        = RW'(den);
        sh_re     = {r_re[RW-2:0], low_re[QW-1]};
        sh_im     = {r_im[RW-2:0], low_im[QW-1]};
        ge_re     = sh_re >= dx;
        ge_im     = sh_im >= dx;
        r_re_next = ge_re ? sh_re - dx : sh_re;
        r_im_next = ge_im ? sh_im - dx : sh_im;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_re_o   <= r_re_next;
            r_im_o   <= r_im_next;
            q_re_o   <= {q_re[QW-2:0], ge_re};
            q_im_o   <= {q_im[QW-2:0], ge_im};
            low_re_o <= low_re << 1;
            low_im_o <= low_im << 1;
            den_o    <= den;
            side_o   <= side;
        end
    end

endmodule

// ===== rtl/core/complex_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Pipelined complex ALU on signed fixed point: add, subtract, multiply,
// divide, increment, decrement, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// Stages: input, products, sums of products, scale/saturate and divider setup, one per quotient bit, output.
// Throughput: one item per cycle; each stage holds while the next is full.
// Depth is set by the bit-per-stage divider (DATA_WIDTH + 1 quotient bits).
// Reset: rst_n clears all stage valid bits; datapath registers are not reset.
module complex_arith_unit_core
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W;
    localparam int PW  = 2 * W + 1;
    localparam int RW  = 2 * W + 1;
    localparam int QW  = W + 1;
    localparam int XW  = 2 * W + F;
    localparam int SW  = ((W > F + 1) ? W : F + 2) + 1;
    localparam int NS  = QW + 5;
    localparam int OUT = NS - 1;

    typedef struct packed {
        logic                is_div;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
        logic                sat_re;
        logic                sat_im;
        logic                ovf;
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    localparam logic signed [PW-1:0] P_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] S_ONE = SW'(1) << F;
    localparam logic [QW-1:0] Q_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [QW-1:0] Q_NEG = {2'b01, {(W-1){1'b0}}};

    // ---------------- handshake ----------------
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = rsp.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign req.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= req.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [2:0]          act0_reg;
    logic signed [W-1:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            act0_reg <= req.action;
            ar0_reg  <= req.a_real;
            ai0_reg  <= req.a_imag;
            br0_reg  <= req.b_real;
            bi0_reg  <= req.b_imag;
        end
    end

    // ---------------- stage 1: products, simple sums ----------------
    logic [2:0]           act1_reg;
    logic signed [DW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [SW-1:0] s_re_reg, s_im_reg;
    logic signed [SW-1:0] s_re_next, s_im_next;
    logic signed [SW-1:0] xar, xai, xbr, xbi;

    always_comb
    begin
        xar = SW'(ar0_reg);
        xai = SW'(ai0_reg);
        xbr = SW'(br0_reg);
        xbi = SW'(bi0_reg);
        s_re_next = '0;
        s_im_next = '0;
        unique case (act0_reg)
            ACT_ADD:
            begin
                s_re_next = xar + xbr;
                s_im_next = xai + xbi;
            end
            ACT_SUB:
            begin
                s_re_next = xar - xbr;
                s_im_next = xai - xbi;
            end
            ACT_INC:
            begin
                s_re_next = xar + S_ONE;
                s_im_next = xai + S_ONE;
            end
            ACT_DEC:
            begin
                s_re_next = xar - S_ONE;
                s_im_next = xai - S_ONE;
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            act1_reg <= act0_reg;
            p_rr_reg <= DW'(ar0_reg) * DW'(br0_reg);
            p_ii_reg <= DW'(ai0_reg) * DW'(bi0_reg);
            p_ri_reg <= DW'(ar0_reg) * DW'(bi0_reg);
            p_ir_reg <= DW'(ai0_reg) * DW'(br0_reg);
            p_bb_reg <= DW'(br0_reg) * DW'(br0_reg);
            p_cc_reg <= DW'(bi0_reg) * DW'(bi0_reg);
            s_re_reg <= s_re_next;
            s_im_reg <= s_im_next;
        end
    end

    // ---------------- stage 2: sums of products ----------------
    logic [2:0]           act2_reg;
    logic signed [PW-1:0] mr_reg, mi_reg, nr_reg, ni_reg, den2_reg;
    logic signed [SW-1:0] s2_re_reg, s2_im_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            act2_reg  <= act1_reg;
            mr_reg    <= PW'(p_rr_reg) - PW'(p_ii_reg);
            mi_reg    <= PW'(p_ri_reg) + PW'(p_ir_reg);
            nr_reg    <= PW'(p_rr_reg) + PW'(p_ii_reg);
            ni_reg    <= PW'(p_ir_reg) - PW'(p_ri_reg);
            den2_reg  <= PW'(p_bb_reg) + PW'(p_cc_reg);
            s2_re_reg <= s_re_reg;
            s2_im_reg <= s_im_reg;
        end
    end

    // ---------------- stage 3: scale/saturate, divider setup ----------------
    function automatic logic [W:0] sat_p(input logic signed [PW-1:0] x);
        logic [W:0] r;
        if (x > P_MAX)
        begin
            r = {1'b1, P_MAX[W-1:0]};
        end
        else if (x < P_MIN)
        begin
            r = {1'b1, P_MIN[W-1:0]};
        end
        else
        begin
            r = {1'b0, x[W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [W:0] sat_s(input logic signed [SW-1:0] x);
        logic [W:0] r;
        if (x > S_MAX)
        begin
            r = {1'b1, S_MAX[W-1:0]};
        end
        else if (x < S_MIN)
        begin
            r = {1'b1, S_MIN[W-1:0]};
        end
        else
        begin
            r = {1'b0, x[W-1:0]};
        end
        return r;
    endfunction

    side_t                side3_next;
    logic [DW-1:0]        den3;
    logic [DW-1:0]        abs_re, abs_im;
    logic [XW-1:0]        x_re, x_im, hi_re, hi_im;
    logic signed [PW-1:0] sc_re, sc_im, neg_nr, neg_ni;
    logic [W:0]           o_re, o_im;

    always_comb
    begin
        den3   = den2_reg[DW-1:0];
        neg_nr = -nr_reg;
        neg_ni = -ni_reg;
        abs_re = nr_reg[PW-1] ? neg_nr[DW-1:0] : nr_reg[DW-1:0];
        abs_im = ni_reg[PW-1] ? neg_ni[DW-1:0] : ni_reg[DW-1:0];
        x_re   = XW'(abs_re) << F;
        x_im   = XW'(abs_im) << F;
        hi_re  = x_re >> QW;
        hi_im  = x_im >> QW;
        sc_re  = mr_reg >>> F;
        sc_im  = mi_reg >>> F;
        if (act2_reg == ACT_MUL)
        begin
            o_re = sat_p(sc_re);
            o_im = sat_p(sc_im);
        end
        else
        begin
            o_re = sat_s(s2_re_reg);
            o_im = sat_s(s2_im_reg);
        end
        side3_next.is_div = act2_reg == ACT_DIV;
        side3_next.dz     = den3 == '0;
        side3_next.neg_re = nr_reg[PW-1];
        side3_next.neg_im = ni_reg[PW-1];
        // quotient would not fit QW bits
        side3_next.sat_re = hi_re >= XW'(den3);
        side3_next.sat_im = hi_im >= XW'(den3);
        side3_next.ovf    = o_re[W] || o_im[W];
        side3_next.res_re = o_re[W-1:0];
        side3_next.res_im = o_im[W-1:0];
    end

    logic [RW-1:0]     dr_re  [QW+1];
    logic [RW-1:0]     dr_im  [QW+1];
    logic [QW-1:0]     dq_re  [QW+1];
    logic [QW-1:0]     dq_im  [QW+1];
    logic [QW-1:0]     dl_re  [QW+1];
    logic [QW-1:0]     dl_im  [QW+1];
    logic [DW-1:0]     dden   [QW+1];
    logic [SIDE_W-1:0] dside  [QW+1];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dr_re[0] <= RW'(hi_re);
            dr_im[0] <= RW'(hi_im);
            dq_re[0] <= '0;
            dq_im[0] <= '0;
            dl_re[0] <= x_re[QW-1:0];
            dl_im[0] <= x_im[QW-1:0];
            dden[0]  <= den3;
            dside[0] <= side3_next;
        end
    end

    // ---------------- stages 4 .. QW+3: one quotient bit each ----------------
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        cau_div_stage #(
            .RW     (RW),
            .QW     (QW),
            .DW     (DW),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk      (clk),
            .en       (en[4+i]),
            .r_re     (dr_re[i]),
            .r_im     (dr_im[i]),
            .q_re     (dq_re[i]),
            .q_im     (dq_im[i]),
            .low_re   (dl_re[i]),
            .low_im   (dl_im[i]),
            .den      (dden[i]),
            .side     (dside[i]),
            .r_re_o   (dr_re[i+1]),
            .r_im_o   (dr_im[i+1]),
            .q_re_o   (dq_re[i+1]),
            .q_im_o   (dq_im[i+1]),
            .low_re_o (dl_re[i+1]),
            .low_im_o (dl_im[i+1]),
            .den_o    (dden[i+1]),
            .side_o   (dside[i+1])
        );
    end

    // ---------------- output stage ----------------
    side_t               sd;
    logic [QW-1:0]       q_re, q_im, qn_re, qn_im;
    logic                ov_re, ov_im;
    logic signed [W-1:0] res_re_next, res_im_next;
    logic                ovf_next, dz_next;

    always_comb
    begin
        sd    = side_t'(dside[QW]);
        q_re  = dq_re[QW];
        q_im  = dq_im[QW];
        qn_re = ~q_re + QW'(1);
        qn_im = ~q_im + QW'(1);
        ov_re = sd.sat_re || (sd.neg_re ? (q_re > Q_NEG) : (q_re > Q_POS));
        ov_im = sd.sat_im || (sd.neg_im ? (q_im > Q_NEG) : (q_im > Q_POS));
        res_re_next = sd.res_re;
        res_im_next = sd.res_im;
        ovf_next    = sd.ovf;
        dz_next     = 1'b0;
        if (sd.is_div)
        begin
            if (sd.dz)
            begin
                res_re_next = '0;
                res_im_next = '0;
                ovf_next    = 1'b0;
                dz_next     = 1'b1;
            end
            else
            begin
                if (ov_re)
                begin
                    res_re_next = sd.neg_re ? Q_NEG[W-1:0] : Q_POS[W-1:0];
                end
                else
                begin
                    res_re_next = sd.neg_re ? qn_re[W-1:0] : q_re[W-1:0];
                end
                if (ov_im)
                begin
                    res_im_next = sd.neg_im ? Q_NEG[W-1:0] : Q_POS[W-1:0];
                end
                else
                begin
                    res_im_next = sd.neg_im ? qn_im[W-1:0] : q_im[W-1:0];
                end
                ovf_next = ov_re || ov_im;
            end
        end
    end

    logic signed [W-1:0] res_re_reg, res_im_reg;
    logic                ovf_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (en[OUT])
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            ovf_reg    <= ovf_next;
            dz_reg     <= dz_next;
        end
    end

    assign rsp.valid       = vld_reg[OUT];
    assign rsp.res_real    = res_re_reg;
    assign rsp.res_imag    = res_im_reg;
    assign rsp.overflow    = ovf_reg;
    assign rsp.div_by_zero = dz_reg;

endmodule

// ===== rtl/core/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic signed [W-1:0] res_real,
    input logic signed [W-1:0] res_imag,
    input logic                overflow,
    input logic                div_by_zero
);

    // a stalled result transfer keeps its valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result valid dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(res_real) && $stable(res_imag))
        else $error("result changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && div_by_zero |-> res_real == '0 && res_imag == '0)
        else $error("divide by zero gave nonzero result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(overflow && div_by_zero))
        else $error("overflow together with divide by zero");

    a_rst: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

endmodule

bind complex_arith_unit_core cau_checker #(.W(DATA_WIDTH)) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .res_real    (rsp.res_real),
    .res_imag    (rsp.res_imag),
    .overflow    (rsp.overflow),
    .div_by_zero (rsp.div_by_zero)
);
